// ===== design/blruc_pkg.sv =====
// Shared types and constants for the byte-budget LRU cache.
package blruc_pkg;

   localparam int SIZE_W      = 24;
   localparam int VAL_W       = 32;
   localparam int KEY_IN_W    = 32;
   localparam int OUT_TOTAL_W = 28;
   localparam int OUT_CNT_W   = 5;

   localparam logic [OUT_TOTAL_W-1:0] TOTAL_MAX     = 28'hFFFFFFF;
   localparam logic [SIZE_W-1:0]      CAP_RESET     = 24'h100000;
   localparam logic                   REG_CAPACITY  = 1'b0;
   localparam logic                   OP_GET        = 1'b0;
   localparam logic                   OP_PUT        = 1'b1;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_TOUCH,
      CMD_UPDATE,
      CMD_EVICT,
      CMD_INSERT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type      cmd;
      logic [SIZE_W-1:0] size;
      logic [VAL_W-1:0]  payload;
   } cell_ctl_type;

endpackage

// ===== design/blruc_cell.sv =====
// One cache slot: key, size, payload, valid flag and recency rank.
module blruc_cell #(
   parameter int ENTRIES = 16,
   parameter int KW      = 32,
   parameter int IDX     = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  blruc_pkg::cell_ctl_type           ctl,
   input  logic                              sel,
   input  logic [$clog2(ENTRIES)-1:0]        ref_rank,
   input  logic [KW-1:0]                     key_in,
   output logic                              match,
   output logic                              valid,
   output logic [$clog2(ENTRIES)-1:0]        rank,
   output logic [blruc_pkg::SIZE_W-1:0]      size,
   output logic [blruc_pkg::VAL_W-1:0]       payload
);
   localparam int RW = $clog2(ENTRIES);

   logic                         valid_ff;
   logic [RW-1:0]                rank_ff;
   logic [KW-1:0]                key_ff;
   logic [blruc_pkg::SIZE_W-1:0] size_ff;
   logic [blruc_pkg::VAL_W-1:0]  payload_ff;
   logic                         touch;

   assign touch = (ctl.cmd == blruc_pkg::CMD_TOUCH) || (ctl.cmd == blruc_pkg::CMD_UPDATE) ||
                  (ctl.cmd == blruc_pkg::CMD_INSERT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= RW'(IDX);
      end else begin
         if (touch) begin
            if (sel) rank_ff <= '0;
            else if (rank_ff < ref_rank) rank_ff <= rank_ff + 1'b1;
         end
         if (sel && ctl.cmd == blruc_pkg::CMD_EVICT) valid_ff <= 1'b0;
         if (sel && ctl.cmd == blruc_pkg::CMD_INSERT) valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && (ctl.cmd == blruc_pkg::CMD_UPDATE || ctl.cmd == blruc_pkg::CMD_INSERT)) begin
         size_ff    <= ctl.size;
         payload_ff <= ctl.payload;
      end
      if (sel && ctl.cmd == blruc_pkg::CMD_INSERT) key_ff <= key_in;
   end

   assign match   = valid_ff && (key_ff == key_in);
   assign valid   = valid_ff;
   assign rank    = rank_ff;
   assign size    = size_ff;
   assign payload = payload_ff;
endmodule

// ===== design/byte_budget_lru_cache_top.sv =====
// Top level of the byte-budget LRU cache: slot cell row, sequencer, ports.
//
//  channel  | ports              | contents
//  ---------+--------------------+------------------------------------------
//  request  | req_t*  (in)       | tuser: opcode; tdata: key, size, value
//  response | rsp_t*  (out)      | tdata: hit, value_out, rejected,
//           |                    |        evicted_count, total_bytes
//  config   | csr_*   (APB)      | reg 0 at 0x0: capacity_bytes
//
// A get or an update goes from accept through lookup, done and the response
// load. A new-key put adds its evict walk, down the ranks from the oldest
// while over budget until the total fits or rank 0 is passed, then a
// placement step that replaces the oldest slot when all are valid, else a
// scan for the lowest free slot. One request in flight at a time.
// Reset clears every slot's valid flag and sets ranks to slot order at once.
// A response held by rsp_tready stalls completion; the next request is
// taken as soon as the current one has moved to the response register.
module byte_budget_lru_cache_top #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   // request: tuser = opcode
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,
   // [31:0] key, [55:32] content_size, [87:56] content_value
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] hit, [32:1] value_out, [33] rejected, [38:34] evicted_count,
   // [66:39] total_bytes, rest zero
   output logic [71:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int RW    = $clog2(ENTRIES);
   localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int TW0   = blruc_pkg::SIZE_W + $clog2(ENTRIES) + 1;
   localparam int TOT_W = (TW0 < 29) ? 29 : TW0;
   localparam int CW0   = $clog2(ENTRIES + 1);
   localparam int CNT_W = (CW0 < 5) ? 5 : CW0;
   localparam logic [RW-1:0] LAST_RANK = RW'(ENTRIES - 1);

   typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EVICT, S_PLACE, S_SCAN, S_DONE} state_type;

   state_type                    state_ff;
   logic                         op_ff;
   logic [KW-1:0]                key_ff;
   logic [blruc_pkg::SIZE_W-1:0] size_ff, cap_ff;
   logic [blruc_pkg::VAL_W-1:0]  val_ff, value_ff;
   logic [TOT_W-1:0]             total_ff, total_in;
   logic [RW-1:0]                vr_ff, scan_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         hit_ff, rej_ff;
   logic                         rsp_valid_ff;
   logic [71:0]                  rsp_data_ff;

   // cell row signals
   blruc_pkg::cell_ctl_type      ctl;
   logic [ENTRIES-1:0]           sel, mv, vv, vsel, ssel;
   logic [RW-1:0]                ref_rank;
   logic [RW-1:0]                c_rank [ENTRIES];
   logic [blruc_pkg::SIZE_W-1:0] c_size [ENTRIES];
   logic [blruc_pkg::VAL_W-1:0]  c_pay  [ENTRIES];

   logic                         hit_any, v_valid, full, s_valid;
   logic [RW-1:0]                m_rank, s_rank;
   logic [blruc_pkg::SIZE_W-1:0] m_size, v_size;
   logic [blruc_pkg::VAL_W-1:0]  m_pay;
   logic                         over;
   logic                         load_rsp;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      blruc_cell #(.ENTRIES(ENTRIES), .KW(KW), .IDX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sel      (sel[i]),
         .ref_rank (ref_rank),
         .key_in   (key_ff),
         .match    (mv[i]),
         .valid    (vv[i]),
         .rank     (c_rank[i]),
         .size     (c_size[i]),
         .payload  (c_pay[i])
      );
      assign vsel[i] = (c_rank[i] == vr_ff);
      assign ssel[i] = (RW'(i) == scan_ff);
   end

   // OR trees over the row: match is one-hot, rank and index selects too
   always_comb begin
      m_rank  = '0;
      m_size  = '0;
      m_pay   = '0;
      v_valid = 1'b0;
      v_size  = '0;
      s_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (mv[i]) begin
            m_rank = m_rank | c_rank[i];
            m_size = m_size | c_size[i];
            m_pay  = m_pay  | c_pay[i];
         end
         if (vsel[i]) begin
            v_valid = v_valid | vv[i];
            v_size  = v_size  | c_size[i];
         end
         if (ssel[i]) s_rank = s_rank | c_rank[i];
      end
   end

   assign hit_any = |mv;
   assign full    = &vv;
   assign s_valid = |(vv & ssel);
   assign over    = ({1'b0, total_ff} + {{(TOT_W + 1 - blruc_pkg::SIZE_W){1'b0}}, size_ff})
                    > {{(TOT_W + 1 - blruc_pkg::SIZE_W){1'b0}}, cap_ff};

   // cell commands for the current step
   always_comb begin
      ctl.cmd     = blruc_pkg::CMD_NONE;
      ctl.size    = size_ff;
      ctl.payload = val_ff;
      sel         = '0;
      ref_rank    = m_rank;
      case (state_ff)
         S_LOOK: begin
            if (hit_any && (op_ff == blruc_pkg::OP_GET)) begin
               ctl.cmd = blruc_pkg::CMD_TOUCH;
               sel     = mv;
            end else if (hit_any && size_ff <= cap_ff) begin
               ctl.cmd = blruc_pkg::CMD_UPDATE;
               sel     = mv;
            end
         end
         S_EVICT: begin
            if (over && v_valid) begin
               ctl.cmd = blruc_pkg::CMD_EVICT;
               sel     = vsel;
            end
         end
         S_PLACE: begin
            if (full) begin
               ctl.cmd  = blruc_pkg::CMD_INSERT;
               sel      = vsel;
               ref_rank = LAST_RANK;
            end
         end
         S_SCAN: begin
            if (!s_valid) begin
               ctl.cmd  = blruc_pkg::CMD_INSERT;
               sel      = ssel;
               ref_rank = s_rank;
            end
         end
         default: ;
      endcase
   end

   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      total_in = total_ff;
      case (state_ff)
         S_LOOK:
            if (hit_any && op_ff == blruc_pkg::OP_PUT && size_ff <= cap_ff)
               total_in = total_ff - TOT_W'(m_size) + TOT_W'(size_ff);
         S_EVICT:
            if (over && v_valid) total_in = total_ff - TOT_W'(v_size);
         S_PLACE:
            if (full) total_in = total_ff - TOT_W'(v_size) + TOT_W'(size_ff);
         S_SCAN:
            if (!s_valid) total_in = total_ff + TOT_W'(size_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         cap_ff       <= blruc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == blruc_pkg::REG_CAPACITY)
            cap_ff <= csr_pwdata[blruc_pkg::SIZE_W-1:0];
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser[0];
                  key_ff   <= req_tdata[KW-1:0];
                  size_ff  <= req_tdata[55:32];
                  val_ff   <= req_tdata[87:56];
                  hit_ff   <= 1'b0;
                  rej_ff   <= 1'b0;
                  value_ff <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               vr_ff <= LAST_RANK;
               if (op_ff == blruc_pkg::OP_GET) begin
                  hit_ff   <= hit_any;
                  value_ff <= hit_any ? m_pay : '0;
                  state_ff <= S_DONE;
               end else if (size_ff > cap_ff) begin
                  rej_ff   <= 1'b1;
                  state_ff <= S_DONE;
               end else if (hit_any) begin
                  hit_ff   <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_EVICT;
               end
            end
            S_EVICT: begin
               if (over) begin
                  if (v_valid) cnt_ff <= cnt_ff + 1'b1;
                  if (vr_ff == '0) begin
                     vr_ff    <= LAST_RANK;
                     state_ff <= S_PLACE;
                  end else begin
                     vr_ff <= vr_ff - 1'b1;
                  end
               end else begin
                  vr_ff    <= LAST_RANK;
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               scan_ff <= '0;
               if (full) begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (!s_valid) state_ff <= S_DONE;
               else scan_ff <= scan_ff + 1'b1;
            end
            S_DONE: begin
               if (load_rsp) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // response word, total saturated to the output width
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {5'b0,
                         (total_ff > TOT_W'(blruc_pkg::TOTAL_MAX)) ?
                            blruc_pkg::TOTAL_MAX : total_ff[blruc_pkg::OUT_TOTAL_W-1:0],
                         cnt_ff[blruc_pkg::OUT_CNT_W-1:0],
                         rej_ff,
                         value_ff,
                         hit_ff};
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == blruc_pkg::REG_CAPACITY) ?
                       {{(32 - blruc_pkg::SIZE_W){1'b0}}, cap_ff} : 32'h0;
endmodule

// ===== design/blruc_checker.sv =====
// Port-level checks for the byte-budget LRU cache, bound to the top level.
module blruc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> !rsp_tdata[0] && rsp_tdata[38:34] == 5'd0)
      else $error("rejected put reports hit or evictions");

   a_value_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32:1] != 32'd0 |-> rsp_tdata[0])
      else $error("value returned without hit");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");
endmodule

bind byte_budget_lru_cache_top blruc_checker u_blruc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/byte_budget_lru_cache_top_tb.sv =====
// Testbench for the byte-budget LRU cache: directed and random requests with a scoreboard.
`timescale 1ns / 100ps

module byte_budget_lru_cache_top_tb;

   localparam int SLOTS = 16;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [blruc_pkg::OUT_TOTAL_W-1:0] total_bytes;
      logic [blruc_pkg::OUT_CNT_W-1:0]   evicted_count;
      logic                              rejected;
      logic [blruc_pkg::VAL_W-1:0]       value_out;
      logic                              hit;
   } cache_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [0:0]   req_tuser = '0;
   // [31:0] key, [55:32] content_size, [87:56] content_value
   logic [87:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [0] hit, [32:1] value_out, [33] rejected, [38:34] evicted_count, [66:39] total_bytes
   logic [71:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   byte_budget_lru_cache_top dut (.*);

   // Predictor state: mirrors the cache slots and recency order.
   logic                             m_valid [SLOTS];
   logic [blruc_pkg::KEY_IN_W-1:0]   m_key   [SLOTS];
   logic [blruc_pkg::SIZE_W-1:0]     m_size  [SLOTS];
   logic [blruc_pkg::VAL_W-1:0]      m_val   [SLOTS];
   int                               m_rank  [SLOTS];
   logic [31:0]                      m_total;
   logic [blruc_pkg::SIZE_W-1:0]     m_cap;

   cache_rsp_type pending_rsps[$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  hold_rsp = 1'b0;   // long receiver stall while set
   bit  idle_rsp = 1'b1;   // random receiver gaps enabled
   logic [blruc_pkg::KEY_IN_W-1:0] key_pool[8];

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void model_reset();
      for (int i = 0; i < SLOTS; i++) begin
         m_valid[i] = 1'b0;
         m_rank[i] = i;
      end
      m_total = '0;
      m_cap = blruc_pkg::CAP_RESET;
   endfunction

   function automatic void promote(int s);
      for (int i = 0; i < SLOTS; i++)
         if (m_rank[i] < m_rank[s]) m_rank[i]++;
      m_rank[s] = 0;
   endfunction

   function automatic int find_slot(logic [blruc_pkg::KEY_IN_W-1:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (m_valid[i] && m_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int oldest_slot();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (m_valid[i] && (best < 0 || m_rank[i] > m_rank[best])) best = i;
      return best;
   endfunction

   function automatic cache_rsp_type predict_lookup(logic op,
                                                    logic [blruc_pkg::KEY_IN_W-1:0] k,
                                                    logic [blruc_pkg::SIZE_W-1:0] sz,
                                                    logic [blruc_pkg::VAL_W-1:0] v);
      cache_rsp_type r;
      int s, vic;
      r = '0;
      if (op == blruc_pkg::OP_GET) begin
         s = find_slot(k);
         if (s >= 0) begin
            r.hit = 1'b1;
            r.value_out = m_val[s];
            promote(s);
         end
      end else if (sz > m_cap) begin
         r.rejected = 1'b1;
      end else begin
         s = find_slot(k);
         if (s >= 0) begin
            r.hit = 1'b1;
            promote(s);
            m_total = m_total - m_size[s] + sz;
            m_size[s] = sz;
            m_val[s] = v;
         end else begin
            // evict from the tail until the new entry fits the budget
            vic = oldest_slot();
            while (m_total + sz > m_cap && vic >= 0) begin
               m_total -= m_size[vic];
               m_valid[vic] = 1'b0;
               r.evicted_count++;
               vic = oldest_slot();
            end
            s = -1;
            for (int i = 0; i < SLOTS; i++)
               if (!m_valid[i] && s < 0) s = i;
            if (s < 0) begin
               s = oldest_slot();
               m_total -= m_size[s];
               m_valid[s] = 1'b0;
               r.evicted_count++;
            end
            m_valid[s] = 1'b1;
            m_key[s] = k;
            m_size[s] = sz;
            m_val[s] = v;
            m_total += sz;
            promote(s);
         end
      end
      r.total_bytes = (m_total > blruc_pkg::TOTAL_MAX) ? blruc_pkg::TOTAL_MAX :
                      m_total[blruc_pkg::OUT_TOTAL_W-1:0];
      return r;
   endfunction

   // Random gap: mostly short, sometimes long.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_request(logic op, logic [blruc_pkg::KEY_IN_W-1:0] k,
                               logic [blruc_pkg::SIZE_W-1:0] sz,
                               logic [blruc_pkg::VAL_W-1:0] v, bit gaps = 1);
      if (gaps) idle_gap();
      @(negedge clock);
      req_tuser  <= op;
      req_tdata  <= {v, sz, k};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsps.push_back(predict_lookup(op, k, sz, v));
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (2 * SLOTS + 8) @(negedge clock);
   endtask

   task automatic write_capacity(logic [blruc_pkg::SIZE_W-1:0] cap);
      wait_drained();
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {blruc_pkg::REG_CAPACITY, 2'b00};
      csr_pwdata <= {8'($urandom_range(0, 255)), cap};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      m_cap = cap;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // Response checker: oldest expectation against each accepted response.
   always @(posedge clock) begin
      cache_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[66:0];
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_rsps.pop_front();
            if (got !== want || rsp_tdata[71:67] !== '0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp hit=%0d val=%h rej=%0d ev=%0d tot=%0d",
                            " / got hit=%0d val=%h rej=%0d ev=%0d tot=%0d"},
                           want.hit, want.value_out, want.rejected, want.evicted_count,
                           want.total_bytes, got.hit, got.value_out, got.rejected,
                           got.evicted_count, got.total_bytes);
            end
         end
      end
   end

   // Receiver ready: random gaps unless held off.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_tready <= 1'b0;
         else if (!idle_rsp) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 :
                           ($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1);
      end
   end

   task automatic test_directed();
      write_capacity(24'd1000);
      send_request(blruc_pkg::OP_GET, 32'h0, 24'd0, 32'h0);           // miss on empty cache
      send_request(blruc_pkg::OP_PUT, 32'hFFFFFFFF, 24'd1001, 32'h1); // over budget, rejected
      send_request(blruc_pkg::OP_PUT, 32'hFFFFFFFF, 24'd1000, 32'hFFFFFFFF); // exactly fits
      send_request(blruc_pkg::OP_GET, 32'hFFFFFFFF, 24'hFFFFFF, 32'hA5A5A5A5);
      send_request(blruc_pkg::OP_PUT, 32'h0, 24'd0, 32'h0);           // zero size, full budget
      send_request(blruc_pkg::OP_PUT, 32'h1, 24'd600, 32'h11);        // evicts the tail
      send_request(blruc_pkg::OP_PUT, 32'h1, 24'd900, 32'h22);        // update to a larger size, within budget
      send_request(blruc_pkg::OP_PUT, 32'h2, 24'd50, 32'h33);         // fits beside the updated entry, no eviction
      for (int i = 0; i < 17; i++)                                    // slot count overflow
         send_request(blruc_pkg::OP_PUT, 32'h100 + i, 24'd0, i);
      send_request(blruc_pkg::OP_GET, 32'h100, 24'd0, 32'h0);
      send_request(blruc_pkg::OP_GET, 32'h110, 24'd0, 32'h0);
   endtask

   task automatic test_budget_changes();
      write_capacity(24'hFFFFFF);
      send_request(blruc_pkg::OP_PUT, 32'hDEAD, 24'hFFFFFF, 32'hBEEF);
      send_request(blruc_pkg::OP_PUT, 32'hCAFE, 24'd1, 32'h1);
      write_capacity(24'd0);                                          // lowered budget
      send_request(blruc_pkg::OP_GET, 32'hDEAD, 24'd0, 32'h0);
      send_request(blruc_pkg::OP_PUT, 32'h5, 24'd0, 32'h5);
      send_request(blruc_pkg::OP_PUT, 32'h6, 24'd1, 32'h6);
   endtask

   task automatic random_phase(int n, logic [blruc_pkg::SIZE_W-1:0] cap, int max_sz);
      logic op;
      logic [blruc_pkg::KEY_IN_W-1:0] k;
      logic [blruc_pkg::SIZE_W-1:0] sz;
      write_capacity(cap);
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      for (int i = 0; i < n; i++) begin
         op = 1'($urandom_range(0, 1));
         k = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
         if ($urandom_range(0, 15) == 0) sz = 24'($urandom());
         else sz = 24'($urandom_range(0, max_sz));
         send_request(op, k, sz, $urandom());
      end
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 20; i++)
            send_request(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                         24'($urandom_range(0, 50)), $urandom(), 1'b0);
      join
   endtask

   task automatic test_no_idle();
      idle_rsp = 1'b0;
      for (int i = 0; i < 40; i++)
         send_request(1'($urandom_range(0, 1)), $urandom_range(0, 20),
                      24'($urandom_range(0, 200)), $urandom(), 1'b0);
      wait_drained();
      idle_rsp = 1'b1;
   endtask

   initial begin
      model_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_budget_changes();
      random_phase(250, 24'd1000, 300);
      random_phase(200, 24'd100000, 20000);
      random_phase(150, 24'hFFFFFF, 24'hFFFFFF);
      test_backpressure();
      test_no_idle();
      random_phase(150, 24'd64, 40);
      wait_drained();
      if (mismatches == 0 && pending_rsps.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
